// ===== sv/dcp_pkg.sv =====
// shared types, constants and fixed-point helpers for the depth-cued palette unit
// no dependencies; imported by the entry pipeline and the top level
package dcp_pkg;

   // unsigned Q1.16 fraction, 1.0 = 65536
   typedef logic [16:0] q16_type;

   localparam q16_type Q16_ONE = 17'h10000;
   localparam logic [3:0] LAST_ENTRY = 4'd9;
   localparam logic [7:0] WHITE_OFFSET_INDEX = 8'd25;

   // one palette entry request handed to the entry pipeline
   typedef struct packed {
      logic        white;
      logic [2:0]  level;
      logic [2:0]  sextant;
      logic [15:0] frac;
      q16_type     bs;
      q16_type     ws;
      q16_type     bv;
      q16_type     wv;
      logic [7:0]  index;
      logic        last;
   } entry_type;

   // one finished palette entry
   typedef struct packed {
      logic [7:0] palette_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] gray;
      logic       last;
   } result_type;

   // depth factor 0.36 .. 1.00
   function automatic q16_type depth_scale(input logic [2:0] level);
      q16_type r;
      unique case (level)
         3'd0:    r = 17'd23593;
         3'd1:    r = 17'd34079;
         3'd2:    r = 17'd44564;
         3'd3:    r = 17'd55050;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // white background value offset 0.60 .. 0
   function automatic q16_type white_offset(input logic [2:0] level);
      q16_type r;
      unique case (level)
         3'd0:    r = 17'd39322;
         3'd1:    r = 17'd29491;
         3'd2:    r = 17'd19661;
         3'd3:    r = 17'd9830;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // white background value slope 0.40 .. 1.00
   function automatic q16_type white_slope(input logic [2:0] level);
      q16_type r;
      unique case (level)
         3'd0:    r = 17'd26214;
         3'd1:    r = 17'd36045;
         3'd2:    r = 17'd45875;
         3'd3:    r = 17'd55706;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // palette index offset 50 per depth level
   function automatic logic [7:0] depth_base(input logic [2:0] level);
      logic [7:0] r;
      unique case (level)
         3'd0:    r = 8'd0;
         3'd1:    r = 8'd50;
         3'd2:    r = 8'd100;
         3'd3:    r = 8'd150;
         default: r = 8'd200;
      endcase
      return r;
   endfunction

   // product of two fractions, rounded half up
   function automatic q16_type qmul(input q16_type a, input q16_type b);
      logic [33:0] p;
      p = 34'(a) * 34'(b) + 34'd32768;
      return p[32:16];
   endfunction

   // percent to fraction: 655*c + floor((36*c + 50) / 100), reciprocal 5243 / 2^19
   function automatic q16_type pct_to_q16(input logic [6:0] pct);
      logic [6:0]  c;
      logic [11:0] x;
      logic [24:0] y;
      c = (pct > 7'd100) ? 7'd100 : pct;
      x = 12'(c) * 12'd36 + 12'd50;
      y = 25'(x) * 25'd5243;
      return 17'(c) * 17'd655 + 17'(y[24:19]);
   endfunction

endpackage

// ===== sv/dcp_req_if.sv =====
// request channel: one color specification per item
// no dependencies
interface dcp_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] color_number;
   logic [8:0] hue_degrees;
   logic [6:0] black_saturation;
   logic [6:0] white_saturation;
   logic [6:0] black_brightness;
   logic [6:0] white_brightness;

   modport source (output valid, color_number, hue_degrees, black_saturation,
                   white_saturation, black_brightness, white_brightness,
                   input ready);
   modport sink (input valid, color_number, hue_degrees, black_saturation,
                 white_saturation, black_brightness, white_brightness,
                 output ready);
endinterface

// ===== sv/dcp_rsp_if.sv =====
// response channel: one palette entry per item
// no dependencies
interface dcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] palette_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] gray;
   logic       last;

   modport source (output valid, palette_index, red, green, blue, gray, last,
                   input ready);
   modport sink (input valid, palette_index, red, green, blue, gray, last,
                 output ready);
endinterface

// ===== sv/dcp_entry_pipe.sv =====
// seven-stage pipeline turning one entry request into an rgb palette entry with gray
// depends on dcp_pkg
module dcp_entry_pipe
   import dcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  entry_type  in_entry,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   localparam int STAGES = 7;

   typedef struct packed {
      logic        white;
      logic [2:0]  level;
      logic [2:0]  sextant;
      logic [15:0] frac;
      q16_type     bs;
      q16_type     m1;
      q16_type     m2;
      logic [7:0]  index;
      logic        last;
   } sa_type;

   typedef struct packed {
      logic [2:0]  sextant;
      logic [15:0] frac;
      q16_type     s;
      q16_type     v;
      logic [7:0]  index;
      logic        last;
   } sb_type;

   typedef struct packed {
      logic [2:0] sextant;
      q16_type    v;
      q16_type    p;
      q16_type    sf;
      q16_type    s1f;
      logic [7:0] index;
      logic       last;
   } sc_type;

   typedef struct packed {
      logic [2:0] sextant;
      q16_type    v;
      q16_type    p;
      q16_type    q;
      q16_type    t;
      logic [7:0] index;
      logic       last;
   } sd_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] index;
      logic       last;
   } se_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [17:0] sum;
      logic [7:0]  index;
      logic        last;
   } sf_type;

   // fraction to 8-bit channel, rounded half up and clamped
   function automatic logic [7:0] to_channel(input q16_type x);
      logic [24:0] c;
      c = 25'(x) * 25'd255 + 25'd32768;
      return (c[24:16] > 9'd255) ? 8'd255 : c[23:16];
   endfunction

   logic [STAGES-1:0] vld_ff, vld_in, load;

   sa_type     a_ff, a_in;
   sb_type     b_ff, b_in;
   sc_type     c_ff, c_in;
   sd_type     d_ff, d_in;
   se_type     e_ff, e_in;
   sf_type     f_ff, f_in;
   result_type g_ff, g_in;

   // stall chain: a stage loads when empty or when its item moves on
   always_comb begin
      load[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !vld_ff[i] || load[i+1];
      end
      vld_in[0] = load[0] ? in_valid : vld_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = load[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   // stage a: depth scaling products
   always_comb begin
      a_in.white   = in_entry.white;
      a_in.level   = in_entry.level;
      a_in.sextant = in_entry.sextant;
      a_in.frac    = in_entry.frac;
      a_in.bs      = in_entry.bs;
      a_in.m1      = qmul(depth_scale(in_entry.level),
                          in_entry.white ? in_entry.ws : in_entry.bv);
      a_in.m2      = qmul(white_slope(in_entry.level), in_entry.wv);
      a_in.index   = in_entry.index;
      a_in.last    = in_entry.last;
   end

   // stage b: pick saturation and value, white value clamped at one
   always_comb begin
      logic [17:0] wsum;
      q16_type     wclamp;
      wsum         = 18'(white_offset(a_ff.level)) + 18'(a_ff.m2);
      wclamp       = (wsum > 18'(Q16_ONE)) ? Q16_ONE : wsum[16:0];
      b_in.sextant = a_ff.sextant;
      b_in.frac    = a_ff.frac;
      b_in.s       = a_ff.white ? a_ff.m1 : a_ff.bs;
      b_in.v       = a_ff.white ? wclamp : a_ff.m1;
      b_in.index   = a_ff.index;
      b_in.last    = a_ff.last;
   end

   // stage c: p and the saturation-by-fraction terms
   always_comb begin
      c_in.sextant = b_ff.sextant;
      c_in.v       = b_ff.v;
      c_in.p       = qmul(b_ff.v, Q16_ONE - b_ff.s);
      c_in.sf      = qmul(b_ff.s, 17'(b_ff.frac));
      c_in.s1f     = qmul(b_ff.s, Q16_ONE - 17'(b_ff.frac));
      c_in.index   = b_ff.index;
      c_in.last    = b_ff.last;
   end

   // stage d: q and t
   always_comb begin
      d_in.sextant = c_ff.sextant;
      d_in.v       = c_ff.v;
      d_in.p       = c_ff.p;
      d_in.q       = qmul(c_ff.v, Q16_ONE - c_ff.sf);
      d_in.t       = qmul(c_ff.v, Q16_ONE - c_ff.s1f);
      d_in.index   = c_ff.index;
      d_in.last    = c_ff.last;
   end

   // stage e: sextant routing and channel conversion
   always_comb begin
      q16_type r, g, b;
      unique case (d_ff.sextant)
         3'd0:    begin r = d_ff.v; g = d_ff.t; b = d_ff.p; end
         3'd1:    begin r = d_ff.q; g = d_ff.v; b = d_ff.p; end
         3'd2:    begin r = d_ff.p; g = d_ff.v; b = d_ff.t; end
         3'd3:    begin r = d_ff.p; g = d_ff.q; b = d_ff.v; end
         3'd4:    begin r = d_ff.t; g = d_ff.p; b = d_ff.v; end
         default: begin r = d_ff.v; g = d_ff.p; b = d_ff.q; end
      endcase
      e_in.red   = to_channel(r);
      e_in.green = to_channel(g);
      e_in.blue  = to_channel(b);
      e_in.index = d_ff.index;
      e_in.last  = d_ff.last;
   end

   // stage f: weighted luma sum
   always_comb begin
      f_in.red   = e_ff.red;
      f_in.green = e_ff.green;
      f_in.blue  = e_ff.blue;
      f_in.sum   = 18'(e_ff.red) * 18'd297 + 18'(e_ff.green) * 18'd589
                 + 18'(e_ff.blue) * 18'd114;
      f_in.index = e_ff.index;
      f_in.last  = e_ff.last;
   end

   // stage g: divide the sum by 1000, reciprocal 1073742 / 2^30
   always_comb begin
      logic [38:0] prod;
      prod               = 39'(f_ff.sum) * 39'd1073742;
      g_in.palette_index = f_ff.index;
      g_in.red           = f_ff.red;
      g_in.green         = f_ff.green;
      g_in.blue          = f_ff.blue;
      g_in.gray          = prod[37:30];
      g_in.last          = f_ff.last;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load[0]) a_ff <= a_in;
      if (load[1]) b_ff <= b_in;
      if (load[2]) c_ff <= c_in;
      if (load[3]) d_ff <= d_in;
      if (load[4]) e_ff <= e_in;
      if (load[5]) f_ff <= f_in;
      if (load[6]) g_ff <= g_in;
   end

   assign in_ready   = load[0];
   assign out_valid  = vld_ff[STAGES-1];
   assign out_result = g_ff;

   // the tenth entry of a run lands in the front white slots
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_result.last |-> out_result.palette_index >= 8'd226)
      else $error("last entry with a back-level palette index");

   // gray is a weighted mean, so it never exceeds the brightest channel
   a_gray_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_result.gray <= out_result.red
                     || out_result.gray <= out_result.green
                     || out_result.gray <= out_result.blue))
      else $error("gray above every channel");

endmodule

// ===== sv/depth_cued_palette_from_hsv_unit.sv =====
// top level: takes one hsv color specification and emits its ten depth-cued palette entries
// depends on dcp_pkg, dcp_req_if, dcp_rsp_if and dcp_entry_pipe
//
// Each accepted specification with a color number of 1 to 25 produces ten palette
// entries, black then white background for depth levels 0 to 4, one entry per cycle
// while the entry pipeline is ready; the next specification is taken in the same
// cycle as the tenth entry is issued. Color numbers outside 1 to 25, or ones whose
// front white slot would not fit in PALETTE_ENTRIES, are taken and dropped. The
// entries are issued by the entry sequencer from the held specification registers
// into a seven-stage entry pipeline, stages a to g, and a stalled response side
// holds the pipeline without losing entries.
module depth_cued_palette_from_hsv_unit
   import dcp_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
) (
   input logic      clock,
   input logic      reset,
   dcp_req_if.sink  req,
   dcp_rsp_if.source rsp
);

   logic        run_ff, run_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [4:0]  num_ff;
   logic [2:0]  sext_ff, sext_in;
   logic [15:0] frac_ff, frac_in;
   q16_type     bs_ff, ws_ff, bv_ff, wv_ff;

   logic        req_fire, issue_fire, last_issue, spec_ok, pipe_ready;
   logic        pipe_valid;
   entry_type   entry;
   result_type  result;

   // color number check, palette size included
   assign spec_ok = (req.color_number >= 5'd1) && (req.color_number <= 5'd25)
                 && ((10'(req.color_number) + 10'd225) < 10'(PALETTE_ENTRIES));

   // hue split into sextant and fraction, fraction = 1092*rem + floor(4*rem/15)
   always_comb begin
      logic [3:0]  quo;
      logic [8:0]  rem9;
      logic [7:0]  z;
      logic [20:0] fq;
      priority if (req.hue_degrees < 9'd60)  quo = 4'd0;
      else if (req.hue_degrees < 9'd120)     quo = 4'd1;
      else if (req.hue_degrees < 9'd180)     quo = 4'd2;
      else if (req.hue_degrees < 9'd240)     quo = 4'd3;
      else if (req.hue_degrees < 9'd300)     quo = 4'd4;
      else if (req.hue_degrees < 9'd360)     quo = 4'd5;
      else if (req.hue_degrees < 9'd420)     quo = 4'd6;
      else if (req.hue_degrees < 9'd480)     quo = 4'd7;
      else                                   quo = 4'd8;
      rem9    = req.hue_degrees - 9'(quo) * 9'd60;
      z       = 8'(rem9[5:0]) << 2;
      fq      = 21'(z) * 21'd4370;
      sext_in = (quo > 4'd5) ? 3'd5 : quo[2:0];
      frac_in = 16'(rem9[5:0]) * 16'd1092 + 16'(fq[20:16]);
   end

   // entry sequencer handshake
   assign issue_fire = run_ff && pipe_ready;
   assign last_issue = issue_fire && (cnt_ff == LAST_ENTRY);
   assign req.ready  = !run_ff || last_issue;
   assign req_fire   = req.valid && req.ready;

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      priority if (req_fire) begin
         run_in = spec_ok;
         cnt_in = 4'd0;
      end else if (last_issue) begin
         run_in = 1'b0;
         cnt_in = 4'd0;
      end else if (issue_fire) begin
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= 4'd0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   // held specification, fractions converted on the way in
   always_ff @(posedge clock) begin
      if (req_fire) begin
         num_ff  <= req.color_number;
         sext_ff <= sext_in;
         frac_ff <= frac_in;
         bs_ff   <= pct_to_q16(req.black_saturation);
         ws_ff   <= pct_to_q16(req.white_saturation);
         bv_ff   <= pct_to_q16(req.black_brightness);
         wv_ff   <= pct_to_q16(req.white_brightness);
      end
   end

   // current entry: depth level from the upper count bits, background from bit 0
   always_comb begin
      entry.white   = cnt_ff[0];
      entry.level   = cnt_ff[3:1];
      entry.sextant = sext_ff;
      entry.frac    = frac_ff;
      entry.bs      = bs_ff;
      entry.ws      = ws_ff;
      entry.bv      = bv_ff;
      entry.wv      = wv_ff;
      entry.index   = 8'(num_ff) + depth_base(cnt_ff[3:1])
                    + (cnt_ff[0] ? WHITE_OFFSET_INDEX : 8'd0);
      entry.last    = (cnt_ff == LAST_ENTRY);
   end

   assign pipe_valid = run_ff;

   dcp_entry_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pipe_valid),
      .in_ready   (pipe_ready),
      .in_entry   (entry),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_result (result)
   );

   assign rsp.palette_index = result.palette_index;
   assign rsp.red           = result.red;
   assign rsp.green         = result.green;
   assign rsp.blue          = result.blue;
   assign rsp.gray          = result.gray;
   assign rsp.last          = result.last;

   // an idle sequencer always restarts from the first entry
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> cnt_ff == 4'd0)
      else $error("entry count left over while idle");

   // a run ends after its tenth entry unless a new item starts in that cycle
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      last_issue && !req_fire |=> !run_ff)
      else $error("run continues past its tenth entry");

endmodule
